/* rtl/core/r2s_pkg.sv */
// r2s_pkg: shared constants and controller/datapath interface types for the r2 score engine
// no dependencies
`default_nettype none

package r2s_pkg;

    localparam int DEF_MAX_PAIRS = 1024;
    localparam int SAMPLE_W      = 16;
    localparam int SCORE_W       = 32;
    localparam int PC_W          = 11;
    localparam int FRAC_W        = 16;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic mean_start;
        logic mean_take;
        logic disp_issue;
        logic quot_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic issue_done;
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/core/r2s_ram.sv */
// r2s_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module r2s_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/r2s_div.sv */
// r2s_div: unsigned restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module r2s_div #(
    parameter int DW = 59
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

`default_nettype wire

/* rtl/core/r2s_ctrl.sv */
// r2s_ctrl: sequencing state machine for load, mean, dispersion pass and score divide
// depends on r2s_pkg
`default_nettype none

module r2s_ctrl
    import r2s_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        IDLE,
        ACC,
        MEAN_GO,
        MEAN_WAIT,
        DISP,
        QUOT_GO,
        QUOT_WAIT,
        FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ACC;
                end
            end
            ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = sts.last ? MEAN_GO : IDLE;
            end
            MEAN_GO:
            begin
                cmd.mean_start = 1'b1;
                state_next     = MEAN_WAIT;
            end
            MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_take = 1'b1;
                    state_next    = DISP;
                end
            end
            DISP:
            begin
                cmd.disp_issue = !sts.issue_done;
                if (sts.issue_done && !sts.pipe_busy)
                begin
                    state_next = QUOT_GO;
                end
            end
            QUOT_GO:
            begin
                cmd.quot_start = 1'b1;
                state_next     = QUOT_WAIT;
            end
            QUOT_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = FIN;
                end
            end
            FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == IDLE)
        else $error("finish did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.accumulate)
        else $error("captured beat not accumulated");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.quot_start |-> !sts.pipe_busy)
        else $error("score divide started before dispersion drained");

endmodule

`default_nettype wire

/* rtl/core/r2s_dp.sv */
// r2s_dp: accumulators, observed store, dispersion pipeline, shared divider and result register
// depends on r2s_pkg, r2s_ram, r2s_div
`default_nettype none

module r2s_dp
    import r2s_pkg::*;
#(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [SAMPLE_W-1:0] predicted,
    input  wire logic [SAMPLE_W-1:0] observed,
    input  wire logic                last_pair,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [SCORE_W-1:0]  r2_score,
    output logic      [PC_W-1:0]     pair_count,
    output logic                     overflowed
);

    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int ADDR_W = $clog2(MAX_PAIRS);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int ACC_W  = SQ_W + CNT_W;
    localparam int DW     = ACC_W + FRAC_W;
    localparam logic [DW-1:0] ONE_Q = DW'(64'h0000_0000_0001_0000);
    localparam logic [DW-1:0] SAT_Q = DW'(64'h0000_0000_8001_0000);

    logic [SAMPLE_W-1:0] pred_reg, obs_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    count_reg, idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [ACC_W-1:0]    err_reg, disp_reg;
    logic                drop_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic                v1_reg, v2_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic                out_valid_reg;
    logic [SCORE_W-1:0]  score_reg;
    logic [PC_W-1:0]     pc_reg;
    logic                ovf_reg;

    logic                room;
    logic signed [SAMPLE_W:0]     err_d, dev_d;
    logic signed [2*SAMPLE_W+1:0] err_sq, dev_sq;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SUM_W-1:0]    sum_abs;
    logic [DW-1:0]       div_a, div_b, quo;
    logic                div_done;
    logic [SAMPLE_W-1:0] mean_mag;

    assign room    = (count_reg < CNT_W'(MAX_PAIRS));
    assign err_d   = $signed({obs_reg[SAMPLE_W-1], obs_reg})
                   - $signed({pred_reg[SAMPLE_W-1], pred_reg});
    assign err_sq  = err_d * err_d;
    assign dev_d   = $signed({rd_data[SAMPLE_W-1], rd_data})
                   - $signed({mean_reg[SAMPLE_W-1], mean_reg});
    assign dev_sq  = dev_d * dev_d;
    assign sum_abs = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign mean_mag = quo[SAMPLE_W-1:0];

    always_comb
    begin
        if (cmd.mean_start)
        begin
            div_a = DW'(sum_abs);
            div_b = (count_reg == '0) ? DW'(1) : DW'(count_reg);
        end
        else
        begin
            div_a = {err_reg, {FRAC_W{1'b0}}};
            div_b = (disp_reg == '0) ? DW'(1) : DW'(disp_reg);
        end
    end

    r2s_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_PAIRS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.accumulate && room),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (obs_reg),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    r2s_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mean_start || cmd.quot_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            err_reg       <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            disp_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accumulate)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SUM_W'($signed(obs_reg));
                    err_reg   <= err_reg + ACC_W'(err_sq[SQ_W-1:0]);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.mean_take)
            begin
                idx_reg  <= '0;
                disp_reg <= '0;
            end
            else if (cmd.disp_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            v1_reg <= cmd.disp_issue;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                disp_reg <= disp_reg + ACC_W'(sq_reg);
            end
            if (cmd.finish)
            begin
                count_reg     <= '0;
                sum_reg       <= '0;
                err_reg       <= '0;
                drop_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pred_reg <= predicted;
            obs_reg  <= observed;
            last_reg <= last_pair;
        end
        if (cmd.mean_take)
        begin
            mean_reg <= sum_reg[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
        end
        sq_reg <= dev_sq[SQ_W-1:0];
        if (cmd.finish)
        begin
            score_reg <= (quo >= SAT_Q) ? {1'b1, {(SCORE_W-1){1'b0}}}
                                        : SCORE_W'(ONE_Q - quo);
            pc_reg    <= PC_W'(count_reg);
            ovf_reg   <= drop_reg;
        end
    end

    assign sts.last       = last_reg;
    assign sts.div_done   = div_done;
    assign sts.issue_done = (idx_reg == count_reg);
    assign sts.pipe_busy  = v1_reg || v2_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign r2_score   = score_reg;
    assign pair_count = pc_reg;
    assign overflowed = ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PAIRS))
        else $error("pair count beyond store depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.disp_issue |-> idx_reg < count_reg)
        else $error("dispersion read past stored pairs");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg && count_reg == '0)
        else $error("result not posted or set not cleared");

endmodule

`default_nettype wire

/* rtl/core/r2_score_engine.sv */
// r2_score_engine: top level of the streaming r2 score engine
// depends on r2s_pkg, r2s_ctrl, r2s_dp
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | predicted, observed, last_pair
//   out     | out_valid / out_stall| r2_score, pair_count, overflowed
//
// each pair is captured, then stored and accumulated (dropped when full), before the next is taken
// a last pair is followed by a mean divide, a dispersion pass over the N pairs stored and a
// score divide on the shared divider of DW = 48 + clog2(MAX_PAIRS+1) bits, one bit per cycle
// in_stall is high for the cycle after each beat, and after a last beat until its result posts
// a posted result waits in its own register while the next set loads
// async active-low reset clears all counters and sums; the store is not cleared
`default_nettype none

module r2_score_engine
    import r2s_pkg::*;
#(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [SAMPLE_W-1:0] predicted,
    input  wire logic [SAMPLE_W-1:0] observed,
    input  wire logic                last_pair,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [SCORE_W-1:0]  r2_score,
    output logic      [PC_W-1:0]     pair_count,
    output logic                     overflowed
);

    cmd_t cmd;
    sts_t sts;

    r2s_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    r2s_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .predicted  (predicted),
        .observed   (observed),
        .last_pair  (last_pair),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .r2_score   (r2_score),
        .pair_count (pair_count),
        .overflowed (overflowed)
    );

endmodule

`default_nettype wire
